>>> src/elsp_pkg.sv
// ----------------------------------------------------------------------------
// elsp_pkg
// Shared types and constants of the extended attribute list stream parser.
// ----------------------------------------------------------------------------
`default_nettype none

package elsp_pkg;

   // Bytes that carry the total list size at the head of the blob.
   localparam int unsigned SIZE_BYTES = 4;
   // Fewest bytes that must be left in the list for an entry to start.
   localparam int unsigned ENTRY_MIN = 6;
   // Default depth of the queue between the parser and the output stage.
   localparam int unsigned QUEUE_DEPTH = 4;

   // Result kinds.
   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_NAME   = 2'd1;
   localparam logic [1:0] KIND_VALUE  = 2'd2;
   localparam logic [1:0] KIND_STATUS = 2'd3;

   // List status codes.
   localparam logic [1:0] ST_OK           = 2'd0;
   localparam logic [1:0] ST_LEN_MISMATCH = 2'd1;
   localparam logic [1:0] ST_INVALID      = 2'd2;

   typedef enum logic [2:0] {
      PH_SIZE,
      PH_HDR,
      PH_NAME,
      PH_TERM,
      PH_VALUE,
      PH_DONE,
      PH_ERROR
   } phase_type;

   // Work for the output stage caused by one request: an optional entry
   // result (header, name or value byte) and an optional closing status.
   typedef struct packed {
      logic        first_vld;
      logic [1:0]  first_kind;
      logic [7:0]  entry_flags;
      logic [7:0]  name_length;
      logic [15:0] value_length;
      logic [7:0]  data_byte;
      logic        stat_vld;
      logic [1:0]  status;
      logic [31:0] entry_count;
   } elsp_cmd_type;

endpackage

`default_nettype wire

>>> src/elsp_front.sv
// ----------------------------------------------------------------------------
// elsp_front
// Parser front end: classifies one blob byte per cycle when req_accept is set.
// ----------------------------------------------------------------------------
`default_nettype none

module elsp_front (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_accept,
   input  wire [7:0]             byte_in,
   input  wire                   blob_end,
   output logic                  cmd_valid,
   output elsp_pkg::elsp_cmd_type cmd
);
   import elsp_pkg::*;

   localparam logic [31:0] OFFSET_MAX = 32'hFFFF_FFFF;

   phase_type   phase_ff, phase_in;
   logic [31:0] list_size_ff, list_size_in;
   logic [31:0] offset_ff, offset_in;
   logic [15:0] field_counter_ff, field_counter_in;
   logic [7:0]  cur_flags_ff, cur_flags_in;
   logic [7:0]  cur_name_length_ff, cur_name_length_in;
   logic [15:0] cur_value_length_ff, cur_value_length_in;
   logic [31:0] count_ff, count_in;
   logic [1:0]  error_ff, error_in;

   logic [31:0] size_acc;
   logic [31:0] size_eff;
   logic [32:0] diff;
   logic        start_done;
   logic        start_short;
   logic [15:0] value_len_full;
   logic [16:0] need;
   logic        overrun;
   logic        do_start;
   logic [15:0] counter_inc;
   logic [1:0]  end_status;

   always_comb begin
      offset_in   = (offset_ff == OFFSET_MAX) ? offset_ff : offset_ff + 32'd1;
      size_acc    = list_size_ff | ({24'd0, byte_in} << {field_counter_ff[1:0], 3'b000});
      size_eff    = (phase_ff == PH_SIZE) ? size_acc : list_size_ff;
      // Room left in the list after this byte; the top bit flags an overshoot.
      diff        = {1'b0, size_eff} - {1'b0, offset_in};
      start_done  = diff[32] || (diff == 33'd0);
      start_short = diff[31:0] < 32'(ENTRY_MIN);
      value_len_full = {byte_in, cur_value_length_ff[7:0]};
      need        = {9'd0, cur_name_length_ff} + 17'd1 + {1'b0, value_len_full};
      overrun     = {15'd0, need} > diff[31:0];
      counter_inc = field_counter_ff + 16'd1;
   end

   always_comb begin
      phase_in            = phase_ff;
      list_size_in        = list_size_ff;
      field_counter_in    = field_counter_ff;
      cur_flags_in        = cur_flags_ff;
      cur_name_length_in  = cur_name_length_ff;
      cur_value_length_in = cur_value_length_ff;
      count_in            = count_ff;
      error_in            = error_ff;
      do_start            = 1'b0;
      cmd                 = '0;
      end_status          = ST_OK;

      case (phase_ff)
         PH_SIZE: begin
            list_size_in     = size_acc;
            field_counter_in = counter_inc;
            if (field_counter_ff[1:0] == 2'(SIZE_BYTES - 1)) begin
               field_counter_in = '0;
               do_start         = 1'b1;
            end
         end
         PH_HDR: begin
            case (field_counter_ff[1:0])
               2'd0: begin
                  cur_flags_in     = byte_in;
                  field_counter_in = counter_inc;
               end
               2'd1: begin
                  cur_name_length_in = byte_in;
                  field_counter_in   = counter_inc;
               end
               2'd2: begin
                  cur_value_length_in = {8'd0, byte_in};
                  field_counter_in    = counter_inc;
               end
               default: begin
                  cur_value_length_in = value_len_full;
                  if (overrun) begin
                     phase_in = PH_ERROR;
                     error_in = ST_INVALID;
                  end else begin
                     cmd.first_vld    = 1'b1;
                     cmd.first_kind   = KIND_HEADER;
                     cmd.entry_flags  = cur_flags_ff;
                     cmd.name_length  = cur_name_length_ff;
                     cmd.value_length = value_len_full;
                     field_counter_in = '0;
                     phase_in = (cur_name_length_ff != 8'd0) ? PH_NAME : PH_TERM;
                  end
               end
            endcase
         end
         PH_NAME: begin
            cmd.first_vld    = 1'b1;
            cmd.first_kind   = KIND_NAME;
            cmd.data_byte    = byte_in;
            field_counter_in = counter_inc;
            if (counter_inc >= {8'd0, cur_name_length_ff}) begin
               field_counter_in = '0;
               phase_in         = PH_TERM;
            end
         end
         PH_TERM: begin
            field_counter_in = '0;
            if (cur_value_length_ff != 16'd0) begin
               phase_in = PH_VALUE;
            end else begin
               count_in = count_ff + 32'd1;
               do_start = 1'b1;
            end
         end
         PH_VALUE: begin
            cmd.first_vld    = 1'b1;
            cmd.first_kind   = KIND_VALUE;
            cmd.data_byte    = byte_in;
            field_counter_in = counter_inc;
            if (counter_inc >= cur_value_length_ff) begin
               field_counter_in = '0;
               count_in         = count_ff + 32'd1;
               do_start         = 1'b1;
            end
         end
         default: begin
         end
      endcase

      // Open the next entry, close the list at its end, or fail if it runs short.
      if (do_start) begin
         if (start_done) begin
            phase_in = PH_DONE;
         end else if (start_short) begin
            phase_in = PH_ERROR;
            error_in = ST_INVALID;
         end else begin
            phase_in         = PH_HDR;
            field_counter_in = '0;
         end
      end

      if (phase_in == PH_SIZE) begin
         end_status = ST_LEN_MISMATCH;
      end else if (!start_done || error_in != ST_OK) begin
         end_status = ST_INVALID;
      end else begin
         end_status = ST_OK;
      end

      if (blob_end) begin
         cmd.stat_vld    = 1'b1;
         cmd.status      = end_status;
         cmd.entry_count = (end_status == ST_OK) ? count_in : 32'd0;
         // The final byte returns the parser to its reset state.
         phase_in            = PH_SIZE;
         list_size_in        = '0;
         field_counter_in    = '0;
         cur_flags_in        = '0;
         cur_name_length_in  = '0;
         cur_value_length_in = '0;
         count_in            = '0;
         error_in            = ST_OK;
      end

      cmd_valid = req_accept && (cmd.first_vld || cmd.stat_vld);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff            <= PH_SIZE;
         list_size_ff        <= '0;
         offset_ff           <= '0;
         field_counter_ff    <= '0;
         cur_flags_ff        <= '0;
         cur_name_length_ff  <= '0;
         cur_value_length_ff <= '0;
         count_ff            <= '0;
         error_ff            <= ST_OK;
      end else if (req_accept) begin
         phase_ff            <= phase_in;
         list_size_ff        <= list_size_in;
         offset_ff           <= blob_end ? 32'd0 : offset_in;
         field_counter_ff    <= field_counter_in;
         cur_flags_ff        <= cur_flags_in;
         cur_name_length_ff  <= cur_name_length_in;
         cur_value_length_ff <= cur_value_length_in;
         count_ff            <= count_in;
         error_ff            <= error_in;
      end
   end

endmodule

`default_nettype wire

>>> src/elsp_queue.sv
// ----------------------------------------------------------------------------
// elsp_queue
// Short first-in first-out queue between the parser and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module elsp_queue #(
   parameter int unsigned DEPTH = elsp_pkg::QUEUE_DEPTH
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    push,
   input  elsp_pkg::elsp_cmd_type push_data,
   output logic                   full,
   input  wire                    pop,
   output logic                   empty,
   output elsp_pkg::elsp_cmd_type head
);
   import elsp_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   elsp_cmd_type     mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   always_comb begin
      full      = (count_ff == CNT_FULL);
      empty     = (count_ff == '0);
      head      = mem_ff[rd_ptr_ff];
      do_push   = push && !full;
      do_pop    = pop && !empty;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

>>> src/elsp_back.sv
// ----------------------------------------------------------------------------
// elsp_back
// Output stage: turns queued work into one or two registered results.
// ----------------------------------------------------------------------------
`default_nettype none

module elsp_back (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    queue_empty,
   input  elsp_pkg::elsp_cmd_type queue_head,
   output logic                   queue_pop,
   output logic                   rsp_tvalid,
   input  wire                    rsp_tready,
   output logic [79:0]            rsp_tdata,
   output logic [1:0]             rsp_tuser,
   output logic                   rsp_tlast
);
   import elsp_pkg::*;

   elsp_cmd_type cur_ff;
   logic         busy_ff;
   logic         first_pend_ff;
   logic         taken;
   logic         last_beat;
   logic         load;

   always_comb begin
      taken     = busy_ff && rsp_tready;
      last_beat = first_pend_ff ? !cur_ff.stat_vld : 1'b1;
      load      = !busy_ff || (taken && last_beat);
      queue_pop = load && !queue_empty;

      rsp_tvalid = busy_ff;
      rsp_tdata  = '0;
      if (first_pend_ff) begin
         rsp_tuser       = cur_ff.first_kind;
         rsp_tlast       = 1'b0;
         rsp_tdata[7:0]   = cur_ff.entry_flags;
         rsp_tdata[15:8]  = cur_ff.name_length;
         rsp_tdata[31:16] = cur_ff.value_length;
         rsp_tdata[39:32] = cur_ff.data_byte;
      end else begin
         rsp_tuser        = KIND_STATUS;
         rsp_tlast        = 1'b1;
         rsp_tdata[41:40] = cur_ff.status;
         rsp_tdata[73:42] = cur_ff.entry_count;
      end
   end

   always_ff @(posedge clock) begin
      if (queue_pop) begin
         cur_ff <= queue_head;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         first_pend_ff <= 1'b0;
      end else if (queue_pop) begin
         busy_ff       <= 1'b1;
         first_pend_ff <= queue_head.first_vld;
      end else if (load) begin
         busy_ff       <= 1'b0;
         first_pend_ff <= 1'b0;
      end else if (taken) begin
         first_pend_ff <= 1'b0;
      end
   end

endmodule

`default_nettype wire

>>> src/ea_list_stream_parser.sv
// ----------------------------------------------------------------------------
// ea_list_stream_parser
// Streaming parser for an extended attribute list blob.
// ----------------------------------------------------------------------------
// The blob enters one byte per request on the req_ channel, with req_tlast on
// its final byte. The first four bytes give the little-endian list size; each
// entry then brings flags, name length, a 16-bit little-endian value length,
// the name, one skipped terminator byte and the value. For each entry the
// block returns a header result, then one result per name byte and per value
// byte; the final byte also returns a status result with rsp_tlast set. A byte
// is taken every cycle as long as the output keeps up. A byte that produces
// two results (the final byte of a blob that also completes an entry header
// or carries a name or value byte) is sent as two results in turn, because
// the output register sends one result per cycle; the queue between the
// parser and the output absorbs such bursts and any back-pressure of the
// consumer. A result is held first in the queue and then in the output
// register before it is offered, never in the cycle its request is accepted.
// If the status is not ok, the consumer must discard the entries it already
// received for this blob; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module ea_list_stream_parser #(
   parameter int unsigned QUEUE_DEPTH = elsp_pkg::QUEUE_DEPTH
) (
   input  wire         clock,
   input  wire         reset,
   // Request channel.
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire [7:0]   req_tdata,   // [7:0] byte_in
   input  wire         req_tlast,   // blob_end
   // Result channel.
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [79:0] rsp_tdata,   // [7:0] entry_flags, [15:8] name_length,
                                    // [31:16] value_length, [39:32] data_byte,
                                    // [41:40] status, [73:42] entry_count,
                                    // [79:74] zero
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast    // last
);
   import elsp_pkg::*;

   logic         req_accept;
   logic         cmd_valid;
   elsp_cmd_type cmd;
   logic         queue_full;
   logic         queue_empty;
   logic         queue_pop;
   elsp_cmd_type queue_head;

   // The parser only stalls when the queue has no room for its results.
   assign req_tready = !queue_full;
   assign req_accept = req_tvalid && req_tready;

   elsp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .byte_in    (req_tdata),
      .blob_end   (req_tlast),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd)
   );

   elsp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_valid),
      .push_data (cmd),
      .full      (queue_full),
      .pop       (queue_pop),
      .empty     (queue_empty),
      .head      (queue_head)
   );

   elsp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .queue_head  (queue_head),
      .queue_pop   (queue_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

`default_nettype wire

>>> sim/ea_list_stream_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ea_list_stream_parser_tb
// Self-checking bench for the extended attribute list stream parser.
// ----------------------------------------------------------------------------
// Blobs are built byte by byte and sent as requests. Every accepted request
// also runs through a parser written inside the bench, which queues the
// results that the block must return. Each returned result is compared field
// by field with the oldest queued one. Directed blobs cover the short blob,
// the tiny list size, empty entries, an overrunning entry and a huge list
// size. A long output stall fills the block and stalls its input. Random
// blobs, mostly well formed and partly broken, make up the rest.
// ----------------------------------------------------------------------------

module ea_list_stream_parser_tb;

   import elsp_pkg::*;

   localparam int unsigned ITEMS_TARGET    = 1850;
   localparam int unsigned RSP_HOLD_CYCLES = 300;
   localparam int unsigned WATCHDOG_LIMIT  = 2000;
   localparam int unsigned TAIL_CYCLES     = 20;

   // One result of the block, split into its fields.
   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  flags;
      logic [7:0]  name_len;
      logic [15:0] value_len;
      logic [7:0]  data;
      logic [1:0]  status;
      logic [31:0] count;
      logic        last;
   } ea_result_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   // Results still owed by the block, oldest first.
   ea_result_type ea_results_due[$];
   // Payload of the blob under construction, after the four size bytes.
   logic [7:0]  blob_body[$];

   int          errors           = 0;
   int unsigned items_sent       = 0;
   int unsigned idle_cycles      = 0;
   bit          idle_on          = 1'b1;
   bit          rsp_hold_request = 1'b0;

   // Parser state of the bench.
   phase_type   ps_phase;
   logic [31:0] ps_list_size;
   logic [31:0] ps_offset;
   logic [15:0] ps_field;
   logic [7:0]  ps_flags;
   logic [7:0]  ps_nlen;
   logic [15:0] ps_vlen;
   logic [31:0] ps_entries;
   logic [1:0]  ps_error;

   ea_list_stream_parser uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // ------------------------------------------------------------------------
   // Expected results.
   // ------------------------------------------------------------------------

   function automatic void queue_result(input logic [1:0] kind, input logic [7:0] flags,
                                        input logic [7:0] nlen, input logic [15:0] vlen,
                                        input logic [7:0] data, input logic [1:0] status,
                                        input logic [31:0] count, input logic last);
      ea_result_type r;
      r = '{kind, flags, nlen, vlen, data, status, count, last};
      ea_results_due.push_back(r);
   endfunction

   // State after reset and after every closed blob.
   function automatic void ps_clear();
      ps_phase     = PH_SIZE;
      ps_list_size = '0;
      ps_offset    = '0;
      ps_field     = '0;
      ps_flags     = '0;
      ps_nlen      = '0;
      ps_vlen      = '0;
      ps_entries   = '0;
      ps_error     = ST_OK;
   endfunction

   // An entry may only start with at least ENTRY_MIN bytes left in the list;
   // an exactly consumed list ends the parse without error.
   function automatic void ps_start_entry();
      if (ps_offset >= ps_list_size) begin
         ps_phase = PH_DONE;
      end else if (ps_list_size - ps_offset < ENTRY_MIN) begin
         ps_phase = PH_ERROR;
         ps_error = ST_INVALID;
      end else begin
         ps_phase = PH_HDR;
         ps_field = '0;
      end
   endfunction

   function automatic void ps_entry_done();
      ps_entries++;
      ps_start_entry();
   endfunction

   // Runs one accepted byte through the parser and queues what it returns.
   function automatic void ea_parse_byte(input logic [7:0] b, input logic fin);
      logic [1:0] st;
      // The byte count saturates so that a huge list size still compares right.
      if (ps_offset != 32'hFFFF_FFFF) ps_offset++;
      case (ps_phase)
         PH_SIZE: begin
            ps_list_size |= {24'h000000, b} << (8 * ps_field[1:0]);
            ps_field++;
            if (ps_field >= SIZE_BYTES) begin
               ps_field = '0;
               ps_start_entry();
            end
         end
         PH_HDR: begin
            if (ps_field == 16'd3) begin
               ps_vlen[15:8] = b;
               // Name, terminator and value must fit in what the list has left.
               if ({24'h000000, ps_nlen} + 32'd1 + {16'h0000, ps_vlen}
                   > ps_list_size - ps_offset) begin
                  ps_phase = PH_ERROR;
                  ps_error = ST_INVALID;
               end else begin
                  queue_result(KIND_HEADER, ps_flags, ps_nlen, ps_vlen, 8'h00, ST_OK,
                               32'd0, 1'b0);
                  ps_field = '0;
                  ps_phase = (ps_nlen != 8'd0) ? PH_NAME : PH_TERM;
               end
            end else begin
               if (ps_field == 16'd0) ps_flags = b;
               else if (ps_field == 16'd1) ps_nlen = b;
               else ps_vlen = {8'h00, b};
               ps_field++;
            end
         end
         PH_NAME: begin
            queue_result(KIND_NAME, 8'h00, 8'h00, 16'h0000, b, ST_OK, 32'd0, 1'b0);
            ps_field++;
            if (ps_field >= {8'h00, ps_nlen}) begin
               ps_field = '0;
               ps_phase = PH_TERM;
            end
         end
         PH_TERM: begin
            // The terminator is skipped without a check.
            ps_field = '0;
            if (ps_vlen != 16'd0) ps_phase = PH_VALUE;
            else ps_entry_done();
         end
         PH_VALUE: begin
            queue_result(KIND_VALUE, 8'h00, 8'h00, 16'h0000, b, ST_OK, 32'd0, 1'b0);
            ps_field++;
            if (ps_field >= ps_vlen) begin
               ps_field = '0;
               ps_entry_done();
            end
         end
         default: begin
            // Done or failed: the byte is ignored.
         end
      endcase
      if (fin) begin
         if (ps_phase == PH_SIZE) st = ST_LEN_MISMATCH;
         else if (ps_list_size > ps_offset || ps_error != ST_OK) st = ST_INVALID;
         else st = ST_OK;
         queue_result(KIND_STATUS, 8'h00, 8'h00, 16'h0000, 8'h00, st,
                      (st == ST_OK) ? ps_entries : 32'd0, 1'b1);
         ps_clear();
      end
   endfunction

   // Every request the block accepts is parsed here as well. Outputs are
   // sampled at the edge, before any of this step's updates land.
   always @(posedge clock) begin
      if (reset) ps_clear();
      else if (req_tvalid && req_tready) ea_parse_byte(req_tdata, req_tlast);
   end

   // ------------------------------------------------------------------------
   // Result checking.
   // ------------------------------------------------------------------------

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin : result_check
      ea_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (ea_results_due.size() == 0) begin
            $error("result with nothing pending: kind %0d, tdata 0x%0h", rsp_tuser, rsp_tdata);
            errors++;
         end else begin
            want = ea_results_due.pop_front();
            check_field("kind", 32'(want.kind), 32'(rsp_tuser));
            check_field("entry_flags", 32'(want.flags), 32'(rsp_tdata[7:0]));
            check_field("name_length", 32'(want.name_len), 32'(rsp_tdata[15:8]));
            check_field("value_length", 32'(want.value_len), 32'(rsp_tdata[31:16]));
            check_field("data_byte", 32'(want.data), 32'(rsp_tdata[39:32]));
            check_field("status", 32'(want.status), 32'(rsp_tdata[41:40]));
            check_field("entry_count", want.count, rsp_tdata[73:42]);
            check_field("padding", 32'd0, 32'(rsp_tdata[79:74]));
            check_field("last", 32'(want.last), 32'(rsp_tlast));
         end
      end
   end

   // The run ends if neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("ea_list_stream_parser_tb NOT OK");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Pacing of both channels.
   // ------------------------------------------------------------------------

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int unsigned pick_gap();
      int unsigned r;
      if (!idle_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // The consumer. A hold request from a test stops it for a long stretch,
   // counted here, so that the block fills up and stalls its input.
   initial begin : rsp_pacing
      int unsigned stall;
      forever begin
         if (rsp_hold_request) begin
            rsp_hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
         end else begin
            stall = pick_gap();
            if (stall != 0) begin
               rsp_tready <= 1'b0;
               repeat (stall) @(posedge clock);
            end else begin
               rsp_tready <= 1'b1;
               @(posedge clock);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Request side.
   // ------------------------------------------------------------------------

   // Offers one byte and waits for its handshake. Valid stays high when the
   // next byte follows right away, so it is never dropped and raised in the
   // same step.
   task automatic send_byte(input logic [7:0] b, input logic fin);
      int unsigned gap;
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= fin;
      do @(posedge clock); while (!(req_tvalid && req_tready));
      items_sent++;
      gap = pick_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stops sending and waits until every pending result has come back.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (ea_results_due.size() != 0);
   endtask

   task automatic add_random_bytes(input int unsigned n);
      repeat (n) blob_body.push_back(8'($urandom_range(0, 255)));
   endtask

   task automatic add_entry_header(input logic [7:0] flags, input logic [7:0] nlen,
                                   input logic [15:0] vlen);
      blob_body.push_back(flags);
      blob_body.push_back(nlen);
      blob_body.push_back(vlen[7:0]);
      blob_body.push_back(vlen[15:8]);
   endtask

   // Header, name, terminator and value of one well-formed entry.
   task automatic add_entry(input logic [7:0] flags, input logic [7:0] nlen,
                            input logic [15:0] vlen);
      add_entry_header(flags, nlen, vlen);
      add_random_bytes(nlen + 1 + vlen);
   endtask

   // Sends the size field, the body and trail random bytes, with cut bytes
   // dropped from the end; the final byte carries tlast.
   task automatic send_blob(input logic [31:0] size_field, input int unsigned cut,
                            input int unsigned trail);
      logic [7:0]  bytes[$];
      int unsigned total;
      for (int i = 0; i < 4; i++) bytes.push_back(size_field[8*i +: 8]);
      foreach (blob_body[i]) bytes.push_back(blob_body[i]);
      repeat (trail) bytes.push_back(8'($urandom_range(0, 255)));
      total = bytes.size() - cut;
      for (int i = 0; i < total; i++) send_byte(bytes[i], i == total - 1);
      blob_body.delete();
   endtask

   // ------------------------------------------------------------------------
   // Tests.
   // ------------------------------------------------------------------------

   task automatic test_directed_cases();
      idle_on = 1'b0;
      // Blobs shorter than the size field: length mismatch.
      send_blob(32'h0000_0001, 3, 0);
      send_blob(32'hFFFF_FFFF, 1, 0);
      // A list size of zero: no entries, status ok.
      send_blob(32'h0000_0000, 0, 0);
      // An empty entry followed by a one-byte name, then a byte past the list.
      add_entry(8'hFF, 8'd0, 16'd0);
      add_entry(8'h00, 8'd1, 16'd0);
      send_blob(blob_body.size() + 4, 0, 1);
      // An entry whose value length runs far past the list; later bytes ignored.
      add_entry_header(8'hA5, 8'hFF, 16'hFFFF);
      add_random_bytes(2);
      send_blob(32'd10, 0, 2);
      // The largest list size against a blob of four bytes.
      send_blob(32'hFFFF_FFFF, 0, 0);
      idle_on = 1'b1;
   endtask

   task automatic test_output_backpressure();
      idle_on = 1'b0;
      rsp_hold_request = 1'b1;
      add_entry(8'($urandom_range(0, 255)), 8'd24, 16'd24);
      add_entry(8'($urandom_range(0, 255)), 8'd3, 16'd10);
      send_blob(blob_body.size() + 4, 0, 0);
      idle_on = 1'b1;
   endtask

   task automatic test_random_lists();
      int unsigned n;
      int unsigned r;
      int unsigned len;
      int unsigned k;
      logic [7:0]  nlen;
      logic [15:0] vlen;
      while (items_sent < ITEMS_TARGET) begin
         // Some blobs run with no gaps on either side.
         idle_on = ($urandom_range(0, 3) != 0);
         n = $urandom_range(1, 4);
         for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            nlen = 8'((r < 85) ? $urandom_range(0, 6) : (r < 98) ? $urandom_range(7, 40)
                                                              : $urandom_range(41, 255));
            vlen = 16'(($urandom_range(0, 99) == 0) ? $urandom_range(256, 300)
                                                    : $urandom_range(0, 8));
            // The last entry must span at least ENTRY_MIN bytes.
            if (i == n - 1 && nlen == 0 && vlen == 0) vlen = 16'd1;
            add_entry(8'($urandom_range(0, 255)), nlen, vlen);
         end
         len = blob_body.size() + 4;
         r = $urandom_range(0, 99);
         if (r < 65) begin
            // Well formed, sometimes with bytes past the list size.
            send_blob(len, 0, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0);
         end else if (r < 72) begin
            // Blob ends short of the list, inside the size field or the entries.
            send_blob(len, $urandom_range(1, len - 1), 0);
         end else if (r < 79) begin
            // Too few bytes left in the list for another entry.
            k = $urandom_range(1, 5);
            send_blob(len + k, 0, k + $urandom_range(0, 3));
         end else if (r < 86) begin
            // An entry whose fields overrun the list size.
            k = $urandom_range(2, 12);
            add_entry_header(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                             16'($urandom_range(0, 65535)));
            add_random_bytes(k);
            send_blob(blob_body.size() + 4, 0, $urandom_range(0, 3));
         end else if (r < 90) begin
            // List size larger than the blob.
            send_blob(len + $urandom_range(1, 1000), 0, $urandom_range(0, 3));
         end else if (r < 94) begin
            // List size of four or less: no entries, anything after is ignored.
            blob_body.delete();
            send_blob($urandom_range(0, 4), 0, $urandom_range(0, 8));
         end else if (r < 97) begin
            // Shorter than the size field.
            blob_body.delete();
            send_blob($urandom, $urandom_range(1, 3), 0);
         end else begin
            // Noise.
            blob_body.delete();
            add_random_bytes($urandom_range(1, 20));
            send_blob($urandom_range(0, 1) ? $urandom : 32'hFFFF_FFFF, 0, 0);
         end
         // Now and then the sender waits for every result before going on.
         if ($urandom_range(0, 9) == 0) drain_results();
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      drain_results();
      test_output_backpressure();
      drain_results();
      test_random_lists();
      drain_results();
      // A late or extra result would show up during the tail wait.
      repeat (TAIL_CYCLES) @(posedge clock);
      if (errors == 0 && ea_results_due.size() == 0) begin
         $display("ea_list_stream_parser_tb OK");
      end else begin
         if (ea_results_due.size() != 0)
            $error("%0d results never arrived", ea_results_due.size());
         $display("ea_list_stream_parser_tb NOT OK");
      end
      $finish;
   end

endmodule

>>> files.f
src/elsp_pkg.sv
src/elsp_front.sv
src/elsp_queue.sv
src/elsp_back.sv
src/ea_list_stream_parser.sv
sim/ea_list_stream_parser_tb.sv
